[rtl/core/ues_pkg.sv]
`timescale 1ns / 1ps

package ues_pkg;

    localparam logic [2:0] ENC_NONE    = 3'd0;
    localparam logic [2:0] ENC_UTF16LE = 3'd1;
    localparam logic [2:0] ENC_UTF16BE = 3'd2;
    localparam logic [2:0] ENC_UTF8    = 3'd3;
    localparam logic [2:0] ENC_UTF32LE = 3'd4;
    localparam logic [2:0] ENC_UTF32BE = 3'd5;

    localparam int MASK_UTF16LE = 0;
    localparam int MASK_UTF16BE = 1;
    localparam int MASK_UTF8    = 2;
    localparam int MASK_UTF32LE = 3;
    localparam int MASK_UTF32BE = 4;

    localparam logic [2:0] RULE_ANY   = 3'd0;
    localparam logic [2:0] RULE_A0_BF = 3'd1;
    localparam logic [2:0] RULE_80_9F = 3'd2;
    localparam logic [2:0] RULE_90_BF = 3'd3;
    localparam logic [2:0] RULE_80_8F = 3'd4;

    localparam logic [31:0] BOM32_LE  = 32'h0000_FEFF;
    localparam logic [31:0] BOM32_BE  = 32'hFFFE_0000;
    localparam logic [15:0] UNIT_BOM  = 16'hFEFF;
    localparam logic [15:0] UNIT_SWAP = 16'hFFFE;
    localparam logic [23:0] UTF8_BOM  = 24'hBF_BBEF;
    localparam logic [31:0] MAX_CP    = 32'h0010_FFFF;

    localparam logic [2:0] POS_FULL = 3'd4;

    typedef struct packed {
        logic step;
        logic last;
    } t_step_ctl;

    typedef struct packed {
        logic good;
        logic pending;
        logic failed;
    } t_u16_st;

    function automatic t_u16_st unit16_update(input t_u16_st st, input logic [15:0] u);
        t_u16_st r;
        r = st;
        if (st.failed) begin
            r = st;
        end else if (u == 16'h0000) begin
            r.failed = 1'b1;
        end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            if (st.pending) begin
                r.failed = 1'b1;
            end else begin
                r.pending = 1'b1;
            end
        end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
            if (!st.pending) begin
                r.failed = 1'b1;
            end else begin
                r.good    = 1'b1;
                r.pending = 1'b0;
            end
        end else begin
            if (u[15:8] == 8'h00) begin
                r.good = 1'b1;
            end
            r.pending = 1'b0;
        end
        return r;
    endfunction

    function automatic logic cont_ok(input logic [2:0] rule, input logic [7:0] b);
        logic ok;
        unique case (rule)
            RULE_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
            RULE_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
            RULE_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
            RULE_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
            default:    ok = (b >= 8'h80) && (b <= 8'hBF);
        endcase
        return ok;
    endfunction

endpackage

[rtl/core/ues_utf16_chk.sv]
`timescale 1ns / 1ps

module ues_utf16_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ues_pkg::t_step_ctl i_ctl,
    input  logic               i_unit_valid,
    input  logic [15:0]        i_unit,
    output ues_pkg::t_u16_st   o_status_next
);
    import ues_pkg::*;

    t_u16_st r_status;
    t_u16_st n_status;

    always_comb begin
        n_status = r_status;
        if (i_unit_valid) begin
            n_status = unit16_update(r_status, i_unit);
        end
    end

    assign o_status_next = n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
        end else if (i_ctl.step) begin
            r_status <= i_ctl.last ? t_u16_st'('0) : n_status;
        end
    end

endmodule

[rtl/core/ues_utf8_chk.sv]
`timescale 1ns / 1ps

module ues_utf8_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ues_pkg::t_step_ctl i_ctl,
    input  logic [7:0]         i_byte,
    output logic               o_pass_next
);
    import ues_pkg::*;

    logic [1:0] r_left;
    logic [2:0] r_rule;
    logic       r_seen;
    logic       r_failed;
    logic [1:0] n_left;
    logic [2:0] n_rule;
    logic       n_seen;
    logic       n_failed;

    always_comb begin
        n_left   = r_left;
        n_rule   = r_rule;
        n_seen   = r_seen;
        n_failed = r_failed;
        if (!r_failed) begin
            if (r_left == 2'd0) begin
                n_rule = RULE_ANY;
                if (i_byte <= 8'h7F) begin
                    n_left = 2'd0;
                end else if (i_byte <= 8'hC1 || i_byte >= 8'hF5) begin
                    n_failed = 1'b1;
                end else begin
                    n_seen = 1'b1;
                    if (i_byte <= 8'hDF) begin
                        n_left = 2'd1;
                    end else if (i_byte <= 8'hEF) begin
                        n_left = 2'd2;
                        if (i_byte == 8'hE0) begin
                            n_rule = RULE_A0_BF;
                        end else if (i_byte == 8'hED) begin
                            n_rule = RULE_80_9F;
                        end
                    end else begin
                        n_left = 2'd3;
                        if (i_byte == 8'hF0) begin
                            n_rule = RULE_90_BF;
                        end else if (i_byte == 8'hF4) begin
                            n_rule = RULE_80_8F;
                        end
                    end
                end
            end else if (!cont_ok(r_rule, i_byte)) begin
                n_failed = 1'b1;
            end else begin
                n_left = r_left - 2'd1;
                n_rule = RULE_ANY;
            end
        end
    end

    assign o_pass_next = !n_failed && (n_left == 2'd0) && n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 2'd0;
            r_rule   <= RULE_ANY;
            r_seen   <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                r_left   <= 2'd0;
                r_rule   <= RULE_ANY;
                r_seen   <= 1'b0;
                r_failed <= 1'b0;
            end else begin
                r_left   <= n_left;
                r_rule   <= n_rule;
                r_seen   <= n_seen;
                r_failed <= n_failed;
            end
        end
    end

endmodule

[rtl/core/ues_utf32_chk.sv]
`timescale 1ns / 1ps

module ues_utf32_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ues_pkg::t_step_ctl i_ctl,
    input  logic               i_word_valid,
    input  logic [31:0]        i_word,
    output logic               o_failed_next
);
    import ues_pkg::*;

    logic r_failed;
    logic n_failed;

    always_comb begin
        n_failed = r_failed;
        if (i_word_valid && (i_word == 32'd0 || i_word > MAX_CP)) begin
            n_failed = 1'b1;
        end
    end

    assign o_failed_next = n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b0;
        end else if (i_ctl.step) begin
            r_failed <= i_ctl.last ? 1'b0 : n_failed;
        end
    end

endmodule

[rtl/core/unicode_encoding_sniffer.sv]
`timescale 1ns / 1ps
// Result path: a last byte's verdict passes the input register, then the result register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two sides, so only a last byte waiting on a full, stalled result
// register holds the input.
// Reset: synchronous, active low; clears all checker state and both valid flags.

module unicode_encoding_sniffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_encoding_found,
    output logic [4:0] o_checker_mask
);
    import ues_pkg::*;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic        r_out_valid;
    logic [2:0]  r_out_enc;
    logic [4:0]  r_out_mask;

    logic [2:0]  r_pos;
    logic [1:0]  r_phase;
    logic [31:0] r_first;
    logic [23:0] r_group;
    logic [2:0]  n_pos;
    logic [31:0] n_first;
    logic [23:0] n_group;

    logic        s1_adv;
    logic        in_acc;
    t_step_ctl   ctl;

    logic [7:0]  prev_byte;
    logic        unit_valid;
    logic        word_valid;
    logic [15:0] unit_le;
    logic [15:0] unit_be;
    logic [31:0] word_le;
    logic [31:0] word_be;

    t_u16_st     st16_le;
    t_u16_st     st16_be;
    logic        u8_pass;
    logic        u32le_failed;
    logic        u32be_failed;

    logic [15:0] u0_le;
    logic [15:0] u0_be;
    logic        bom32_any;
    logic [4:0]  mask;
    logic [2:0]  enc;

    assign s1_adv  = r_s1_valid && (!r_s1_last || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    assign ctl.step = s1_adv;
    assign ctl.last = r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
    end

    always_comb begin
        n_first = r_first;
        unique case (r_pos)
            3'd0:    n_first[7:0]   = r_s1_byte;
            3'd1:    n_first[15:8]  = r_s1_byte;
            3'd2:    n_first[23:16] = r_s1_byte;
            3'd3:    n_first[31:24] = r_s1_byte;
            default: n_first = r_first;
        endcase
        n_pos = (r_pos < POS_FULL) ? r_pos + 3'd1 : r_pos;
    end

    always_comb begin
        n_group = r_group;
        unique case (r_phase)
            2'd0:    n_group = {16'h0000, r_s1_byte};
            2'd1:    n_group[15:8] = r_s1_byte;
            2'd2:    n_group[23:16] = r_s1_byte;
            default: n_group = r_group;
        endcase
    end

    assign unit_valid = r_phase[0];
    assign word_valid = (r_phase == 2'd3);
    assign prev_byte  = (r_phase == 2'd1) ? r_group[7:0] : r_group[23:16];
    assign unit_le    = {r_s1_byte, prev_byte};
    assign unit_be    = {prev_byte, r_s1_byte};
    assign word_le    = {r_s1_byte, r_group[23:16], r_group[15:8], r_group[7:0]};
    assign word_be    = {r_group[7:0], r_group[15:8], r_group[23:16], r_s1_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 3'd0;
            r_phase <= 2'd0;
            r_first <= '0;
            r_group <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_pos   <= 3'd0;
                r_phase <= 2'd0;
                r_first <= '0;
                r_group <= '0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= r_phase + 2'd1;
                r_first <= n_first;
                r_group <= n_group;
            end
        end
    end

    ues_utf16_chk u_utf16_le (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_unit_valid  (unit_valid),
        .i_unit        (unit_le),
        .o_status_next (st16_le)
    );

    ues_utf16_chk u_utf16_be (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_unit_valid  (unit_valid),
        .i_unit        (unit_be),
        .o_status_next (st16_be)
    );

    ues_utf8_chk u_utf8 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_byte      (r_s1_byte),
        .o_pass_next (u8_pass)
    );

    ues_utf32_chk u_utf32_le (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_word_valid  (word_valid),
        .i_word        (word_le),
        .o_failed_next (u32le_failed)
    );

    ues_utf32_chk u_utf32_be (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_word_valid  (word_valid),
        .i_word        (word_be),
        .o_failed_next (u32be_failed)
    );

    assign u0_le     = {n_first[15:8], n_first[7:0]};
    assign u0_be     = {n_first[7:0], n_first[15:8]};
    assign bom32_any = (n_pos >= POS_FULL) && (n_first == BOM32_LE || n_first == BOM32_BE);

    always_comb begin
        mask = '0;

        if (n_pos < 3'd2 || bom32_any || u0_le == UNIT_SWAP) begin
            mask[MASK_UTF16LE] = 1'b0;
        end else if (u0_le == UNIT_BOM) begin
            mask[MASK_UTF16LE] = 1'b1;
        end else begin
            mask[MASK_UTF16LE] = !st16_le.failed && st16_le.good;
        end

        if (n_pos < 3'd2 || bom32_any || u0_be == UNIT_SWAP) begin
            mask[MASK_UTF16BE] = 1'b0;
        end else if (u0_be == UNIT_BOM) begin
            mask[MASK_UTF16BE] = 1'b1;
        end else begin
            mask[MASK_UTF16BE] = !st16_be.failed && st16_be.good;
        end

        mask[MASK_UTF8] = ((n_pos >= 3'd3) && (n_first[23:0] == UTF8_BOM)) || u8_pass;

        mask[MASK_UTF32LE] = (n_pos >= POS_FULL) && ((n_first == BOM32_LE) || !u32le_failed);
        mask[MASK_UTF32BE] = (n_pos >= POS_FULL) && ((n_first == BOM32_BE) || !u32be_failed);
    end

    always_comb begin
        priority if (mask[MASK_UTF16LE]) begin
            enc = ENC_UTF16LE;
        end else if (mask[MASK_UTF16BE]) begin
            enc = ENC_UTF16BE;
        end else if (mask[MASK_UTF8]) begin
            enc = ENC_UTF8;
        end else if (mask[MASK_UTF32LE]) begin
            enc = ENC_UTF32LE;
        end else if (mask[MASK_UTF32BE]) begin
            enc = ENC_UTF32BE;
        end else begin
            enc = ENC_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_enc  <= enc;
            r_out_mask <= mask;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_encoding_found = r_out_enc;
    assign o_checker_mask   = r_out_mask;

    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv && r_s1_last))
        else $error("result appeared without a last item");

    a_enc_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_enc == ENC_NONE) == (r_out_mask == 5'd0)))
        else $error("encoding and mask disagree");

    a_le16_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mask[MASK_UTF16LE]) |-> (r_out_enc == ENC_UTF16LE))
        else $error("priority order broken");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_FULL)
        else $error("byte position beyond saturation");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_pos == 3'd0 && r_phase == 2'd0))
        else $error("state not cleared after last item");

endmodule

[bench/unicode_encoding_sniffer_tb.sv]
`timescale 1ns / 1ps

module unicode_encoding_sniffer_tb;
    import ues_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int RANDOM_BYTES  = 550;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_TEXTS    = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} t_stall_mode;
    typedef enum int {TEXT_UTF8, TEXT_UTF16, TEXT_UTF32, TEXT_NOISE} t_text_kind;

    class encoding_scoreboard;
        logic [2:0]  seen;
        logic [1:0]  phase;
        logic [31:0] head;
        logic [23:0] group;
        t_u16_st     le16;
        t_u16_st     be16;
        logic [1:0]  u8_left;
        logic [2:0]  u8_rule;
        logic        u8_multi;
        logic        u8_bad;
        logic        le32_bad;
        logic        be32_bad;
        logic [2:0]  enc_q[$];
        logic [4:0]  mask_q[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            seen     = '0;
            phase    = '0;
            head     = '0;
            group    = '0;
            le16     = '0;
            be16     = '0;
            u8_left  = '0;
            u8_rule  = RULE_ANY;
            u8_multi = 1'b0;
            u8_bad   = 1'b0;
            le32_bad = 1'b0;
            be32_bad = 1'b0;
        endfunction

        function int outstanding();
            return enc_q.size();
        endfunction

        function t_u16_st unit_step(t_u16_st st, logic [15:0] u);
            t_u16_st nxt;
            logic    is_high;
            logic    is_low;
            nxt     = st;
            is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
            is_low  = (u >= 16'hDC00) && (u <= 16'hDFFF);
            if (st.failed)
                return st;
            if (u == 16'h0000 || (is_high && st.pending) || (is_low && !st.pending)) begin
                nxt.failed = 1'b1;
            end else if (is_high) begin
                nxt.pending = 1'b1;
            end else begin
                if (is_low || u[15:8] == 8'h00)
                    nxt.good = 1'b1;
                nxt.pending = 1'b0;
            end
            return nxt;
        endfunction

        function logic cont_fits(logic [2:0] rule, logic [7:0] b);
            case (rule)
                RULE_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
                RULE_80_9F: return b >= 8'h80 && b <= 8'h9F;
                RULE_90_BF: return b >= 8'h90 && b <= 8'hBF;
                RULE_80_8F: return b >= 8'h80 && b <= 8'h8F;
                default:    return b >= 8'h80 && b <= 8'hBF;
            endcase
        endfunction

        function void utf8_byte(logic [7:0] b);
            if (u8_bad)
                return;
            if (u8_left != 0) begin
                if (!cont_fits(u8_rule, b)) begin
                    u8_bad = 1'b1;
                end else begin
                    u8_left = u8_left - 2'd1;
                    u8_rule = RULE_ANY;
                end
                return;
            end
            u8_rule = RULE_ANY;
            if (b <= 8'h7F)
                return;
            if (b <= 8'hC1 || b >= 8'hF5) begin
                u8_bad = 1'b1;
                return;
            end
            u8_multi = 1'b1;
            if (b <= 8'hDF) begin
                u8_left = 2'd1;
            end else if (b <= 8'hEF) begin
                u8_left = 2'd2;
                if (b == 8'hE0)
                    u8_rule = RULE_A0_BF;
                else if (b == 8'hED)
                    u8_rule = RULE_80_9F;
            end else begin
                u8_left = 2'd3;
                if (b == 8'hF0)
                    u8_rule = RULE_90_BF;
                else if (b == 8'hF4)
                    u8_rule = RULE_80_8F;
            end
        endfunction

        function logic utf16_passes(t_u16_st st, logic little);
            logic [15:0] u0;
            u0 = little ? {head[15:8], head[7:0]} : {head[7:0], head[15:8]};
            if (seen < 3'd2)
                return 1'b0;
            if (seen >= POS_FULL && (head == BOM32_LE || head == BOM32_BE))
                return 1'b0;
            if (u0 == UNIT_SWAP)
                return 1'b0;
            if (u0 == UNIT_BOM)
                return 1'b1;
            return !st.failed && st.good;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [7:0]  prev;
            logic [31:0] wl;
            logic [31:0] wb;
            logic [4:0]  mask;
            logic [2:0]  enc;
            if (seen < POS_FULL) begin
                head[8*seen +: 8] = b;
                seen = seen + 3'd1;
            end
            if (phase[0]) begin
                prev = group[8*(phase-1) +: 8];
                le16 = unit_step(le16, {b, prev});
                be16 = unit_step(be16, {prev, b});
            end
            if (phase == 2'd3) begin
                wl = {b, group[23:16], group[15:8], group[7:0]};
                wb = {group[7:0], group[15:8], group[23:16], b};
                if (wl == 32'h0 || wl > MAX_CP)
                    le32_bad = 1'b1;
                if (wb == 32'h0 || wb > MAX_CP)
                    be32_bad = 1'b1;
            end
            if (phase == 2'd0)
                group = {16'h0000, b};
            else if (phase != 2'd3)
                group[8*phase +: 8] = b;
            phase = phase + 2'd1;
            utf8_byte(b);
            if (!last)
                return;
            mask = '0;
            mask[MASK_UTF16LE] = utf16_passes(le16, 1'b1);
            mask[MASK_UTF16BE] = utf16_passes(be16, 1'b0);
            if (seen >= 3'd3 && head[23:0] == UTF8_BOM)
                mask[MASK_UTF8] = 1'b1;
            else
                mask[MASK_UTF8] = !u8_bad && u8_left == 2'd0 && u8_multi;
            mask[MASK_UTF32LE] = seen >= POS_FULL && (head == BOM32_LE || !le32_bad);
            mask[MASK_UTF32BE] = seen >= POS_FULL && (head == BOM32_BE || !be32_bad);
            if (mask[MASK_UTF16LE])
                enc = ENC_UTF16LE;
            else if (mask[MASK_UTF16BE])
                enc = ENC_UTF16BE;
            else if (mask[MASK_UTF8])
                enc = ENC_UTF8;
            else if (mask[MASK_UTF32LE])
                enc = ENC_UTF32LE;
            else if (mask[MASK_UTF32BE])
                enc = ENC_UTF32BE;
            else
                enc = ENC_NONE;
            enc_q.push_back(enc);
            mask_q.push_back(mask);
            clear();
        endfunction

        function void check_verdict(logic [2:0] enc, logic [4:0] mask);
            logic [2:0] want_enc;
            logic [4:0] want_mask;
            if (enc_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: encoding %0d mask %b", enc, mask);
                return;
            end
            want_enc  = enc_q.pop_front();
            want_mask = mask_q.pop_front();
            if (enc !== want_enc) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("encoding mismatch: expected %0d, got %0d", want_enc, enc);
            end
            if (mask !== want_mask) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mask mismatch: expected %b, got %b", want_mask, mask);
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_encoding_found;
    logic [4:0] o_checker_mask;

    encoding_scoreboard sb;
    logic [7:0] text_q[$];
    int         burst_left   = 0;
    int         sent_bytes   = 0;
    int         holds_wanted = 0;
    int         cycles       = 0;

    unicode_encoding_sniffer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_encoding_found (o_encoding_found),
        .o_checker_mask   (o_checker_mask)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("unicode_encoding_sniffer_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_verdict(o_encoding_found, o_checker_mask);
    end

    initial begin : receiver
        t_stall_mode mode;
        int          span;
        int          holds_done;
        int          tick;
        mode       = STALL_NONE;
        span       = 0;
        holds_done = 0;
        tick       = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_wanted) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (span == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(20, 150);
            end
            span--;
            tick++;
            case (mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= (tick % 3 == 0);
            endcase
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [20:0] pick_cp();
        case ($urandom_range(0, 4))
            0: return 21'($urandom_range(0, 32'h7F));
            1: return 21'($urandom_range(32'h80, 32'h7FF));
            2: return $urandom_range(0, 1) ? 21'($urandom_range(32'h800, 32'hD7FF))
                                           : 21'($urandom_range(32'hE000, 32'hFFFF));
            3: return 21'($urandom_range(32'h10000, 32'h10FFFF));
            default: begin
                case ($urandom_range(0, 10))
                    0:       return 21'h000080;
                    1:       return 21'h0007FF;
                    2:       return 21'h000800;
                    3:       return 21'h00D7FF;
                    4:       return 21'h00E000;
                    5:       return 21'h00FFFF;
                    6:       return 21'h010000;
                    7:       return 21'h100000;
                    8:       return 21'h110000;
                    9:       return 21'h000000;
                    default: return 21'h10FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic put_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            text_q.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            text_q.push_back({3'b110, cp[10:6]});
            text_q.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            text_q.push_back({4'b1110, cp[15:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
        end else begin
            text_q.push_back({5'b11110, cp[20:18]});
            text_q.push_back({2'b10, cp[17:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic put_unit16(input logic [15:0] u, input logic big);
        if (big) begin
            text_q.push_back(u[15:8]);
            text_q.push_back(u[7:0]);
        end else begin
            text_q.push_back(u[7:0]);
            text_q.push_back(u[15:8]);
        end
    endtask

    task automatic put_pair(input logic [20:0] cp, input logic big);
        logic [19:0] v;
        v = 20'(cp - 21'h10000);
        put_unit16({6'b110110, v[19:10]}, big);
        put_unit16({6'b110111, v[9:0]}, big);
    endtask

    task automatic put_utf32(input logic [31:0] w, input logic big);
        if (big)
            text_q = {text_q, w[31:24], w[23:16], w[15:8], w[7:0]};
        else
            text_q = {text_q, w[7:0], w[15:8], w[23:16], w[31:24]};
    endtask

    task automatic build_text(input t_text_kind kind);
        int   n;
        logic big;
        text_q.delete();
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        big = 1'($urandom_range(0, 1));
        case (kind)
            TEXT_UTF8: begin
                if ($urandom_range(0, 7) == 0)
                    text_q = {text_q, UTF8_BOM[7:0], UTF8_BOM[15:8], UTF8_BOM[23:16]};
                repeat (n) put_utf8(pick_cp());
            end
            TEXT_UTF16: begin
                case ($urandom_range(0, 7))
                    0:       put_unit16(UNIT_BOM, big);
                    1:       put_unit16(UNIT_SWAP, big);
                    default: ;
                endcase
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0, 1: put_unit16(16'($urandom_range(1, 255)), big);
                        2:    put_pair(21'($urandom_range(32'h10000, 32'h10FFFF)), big);
                        default: begin
                            if ($urandom_range(0, 1))
                                put_unit16(16'($urandom_range(32'h0100, 32'hD7FF)), big);
                            else
                                put_unit16(16'($urandom_range(32'hE000, 32'hFFFF)), big);
                        end
                    endcase
                end
            end
            TEXT_UTF32: begin
                if ($urandom_range(0, 5) == 0)
                    put_utf32({16'h0000, UNIT_BOM}, big);
                repeat (n) put_utf32({11'h000, pick_cp()}, big);
            end
            default: begin
                repeat (n) text_q.push_back(rand_byte());
            end
        endcase
        case ($urandom_range(0, 9))
            0:       text_q[$urandom_range(0, text_q.size() - 1)] = rand_byte();
            1:       void'(text_q.pop_back());
            2:       text_q.push_back(rand_byte());
            default: ;
        endcase
        if (text_q.size() == 0)
            text_q.push_back(rand_byte());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, last);
        sent_bytes++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], k == text_q.size() - 1);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single byte, too short for any checker
        text_q = '{8'h41};
        send_text();
        // byte order marks: UTF-32 LE, UTF-32 BE, UTF-8
        text_q = '{8'hFF, 8'hFE, 8'h00, 8'h00};
        send_text();
        text_q = '{8'h00, 8'h00, 8'hFE, 8'hFF};
        send_text();
        text_q = '{8'hEF, 8'hBB, 8'hBF};
        send_text();
        // narrowed second-byte ranges after ED and F4
        text_q = '{8'hED, 8'h9F, 8'hBF};
        send_text();
        text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        // surrogate pair, little endian
        text_q = '{8'h3D, 8'hD8, 8'h00, 8'hDC};
        send_text();
        // cut-off UTF-8 sequence
        text_q = '{8'hC3};
        send_text();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (holds_wanted == 0 && sent_bytes >= RANDOM_BYTES / 3) begin
                // keep offering short buffers while the result side holds off
                holds_wanted++;
                repeat (HOLD_TEXTS) begin
                    text_q.delete();
                    text_q.push_back(rand_byte());
                    if ($urandom_range(0, 1))
                        text_q.push_back(rand_byte());
                    send_text();
                end
            end
            build_text(t_text_kind'($urandom_range(0, 3)));
            send_text();
        end
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("unicode_encoding_sniffer_tb: clean");
        else
            $display("unicode_encoding_sniffer_tb: errors");
        $finish;
    end

endmodule
